FILE: hw/rtl/crb_pkg.sv
// ----------------------------------------------------------------------------
// crb_pkg
// Shared types and codes for the chunk reassembly buffer.
// ----------------------------------------------------------------------------
package crb_pkg;

    // result status codes
    localparam logic [2:0] STS_ACCEPTED   = 3'd0;
    localparam logic [2:0] STS_BAD_HEADER = 3'd1;
    localparam logic [2:0] STS_DUPLICATE  = 3'd2;
    localparam logic [2:0] STS_COMPLETE   = 3'd3;
    localparam logic [2:0] STS_BUSY       = 3'd4;
    localparam logic [2:0] STS_DRAIN_BYTE = 3'd5;
    localparam logic [2:0] STS_NO_DRAIN   = 3'd6;

    // action codes
    localparam logic ACT_CHUNK = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef enum logic [0:0] {
        CTL_IDLE,
        CTL_DRAIN_RD
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;      // item taken this cycle
        logic load_drain;  // load drained byte into result register
    } crb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic drain_read;  // current item needs a payload memory read
    } crb_sts_t;

endpackage

FILE: hw/rtl/crb_ctrl.sv
// ----------------------------------------------------------------------------
// crb_ctrl
// Handshake controller: item acceptance, drain read wait, result valid.
// ----------------------------------------------------------------------------
module crb_ctrl
    import crb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  crb_sts_t sts,
    output crb_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (in_valid && out_free && sts.drain_read)
                begin
                    state_next = CTL_DRAIN_RD;
                end
            end
            CTL_DRAIN_RD:
            begin
                if (out_free)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall       = 1'b1;
        cmd.accept     = 1'b0;
        cmd.load_drain = 1'b0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                in_stall   = !out_free;
                cmd.accept = in_valid && out_free;
            end
            CTL_DRAIN_RD:
            begin
                cmd.load_drain = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        out_valid_next = (out_valid_reg && out_stall)
                       || (cmd.accept && !sts.drain_read)
                       || cmd.load_drain;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/crb_datapath.sv
// ----------------------------------------------------------------------------
// crb_datapath
// Frame state, slot bookkeeping, payload memory and result register.
// ----------------------------------------------------------------------------
module crb_datapath
    import crb_pkg::*;
#(
    parameter int MAX_CHUNKS  = 16,
    parameter int MAX_PAYLOAD = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  crb_cmd_t    cmd,
    output crb_sts_t    sts,
    input  logic        action,
    input  logic [31:0] frame_id,
    input  logic [15:0] chunk_count,
    input  logic [15:0] chunk_number,
    input  logic [15:0] payload_size,
    input  logic [15:0] byte_index,
    input  logic [7:0]  data_byte,
    input  logic        byte_last,
    input  logic [7:0]  packet_type,
    output logic [2:0]  status,
    output logic        restarted,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic [14:0] frame_size,
    output logic [7:0]  frame_type,
    output logic [31:0] done_frame_id
);

    localparam int SLOT_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int DEPTH  = MAX_CHUNKS * MAX_PAYLOAD;
    localparam int ADDR_W = $clog2(DEPTH);

    // frame state
    logic                  frame_active_reg, frame_active_next;
    logic [31:0]           pending_id_reg, pending_id_next;
    logic [CNT_W-1:0]      expected_reg, expected_next;
    logic [CNT_W-1:0]      received_reg, received_next;
    logic [14:0]           total_reg, total_next;
    logic [MAX_CHUNKS-1:0] filled_reg, filled_next;
    logic                  ignoring_reg, ignoring_next;
    logic                  ignore_dup_reg, ignore_dup_next;
    logic [SLOT_W-1:0]     cur_slot_reg, cur_slot_next;
    logic                  draining_reg, draining_next;
    logic [SLOT_W-1:0]     drain_slot_reg, drain_slot_next;
    logic [LEN_W-1:0]      drain_off_reg, drain_off_next;
    logic                  drain_last_reg, drain_last_next;

    // slot lengths and payload memory (no reset)
    logic [LEN_W-1:0]      slot_len [MAX_CHUNKS];
    logic [7:0]            mem [DEPTH];
    logic [7:0]            rd_data_reg;

    // result register
    logic [2:0]            status_reg, status_next;
    logic                  restarted_reg, restarted_next;
    logic                  out_last_reg, out_last_next;
    logic [14:0]           frame_size_reg, frame_size_next;
    logic [7:0]            frame_type_reg, frame_type_next;
    logic [31:0]           done_id_reg, done_id_next;
    logic [7:0]            out_byte_reg;

    logic                  mem_we;
    logic                  len_we;
    logic [LEN_W-1:0]      commit_len;
    logic [SLOT_W-1:0]     wr_slot;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;

    assign sts.drain_read = (action == ACT_DRAIN) && draining_reg;

    assign rd_addr = ADDR_W'(drain_slot_reg) * ADDR_W'(MAX_PAYLOAD)
                   + ADDR_W'(drain_off_reg);
    assign wr_addr = ADDR_W'(wr_slot) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(byte_index);

    // item processing
    always_comb
    begin
        logic                  hdr_ok;
        logic                  restart_f;
        logic                  open_f;
        logic                  proceed;
        logic [16:0]           len17;
        logic [CNT_W-1:0]      recv_inc;
        logic [14:0]           tot_inc;
        logic [LEN_W-1:0]      cur_len;
        logic [LEN_W:0]        off_inc;
        logic [SLOT_W:0]       slot_inc;

        frame_active_next = frame_active_reg;
        pending_id_next   = pending_id_reg;
        expected_next     = expected_reg;
        received_next     = received_reg;
        total_next        = total_reg;
        filled_next       = filled_reg;
        ignoring_next     = ignoring_reg;
        ignore_dup_next   = ignore_dup_reg;
        cur_slot_next     = cur_slot_reg;
        draining_next     = draining_reg;
        drain_slot_next   = drain_slot_reg;
        drain_off_next    = drain_off_reg;
        drain_last_next   = drain_last_reg;
        status_next       = STS_ACCEPTED;
        restarted_next    = 1'b0;
        out_last_next     = 1'b0;
        frame_size_next   = '0;
        frame_type_next   = '0;
        done_id_next      = '0;
        mem_we            = 1'b0;
        len_we            = 1'b0;
        wr_slot           = cur_slot_reg;
        proceed           = 1'b0;
        restart_f         = 1'b0;
        open_f            = 1'b0;

        hdr_ok = (chunk_count != 16'd0)
              && ({1'b0, chunk_count} <= 17'(MAX_CHUNKS))
              && (chunk_number < chunk_count)
              && (payload_size != 16'd0)
              && ({1'b0, payload_size} <= 17'(MAX_PAYLOAD));

        len17 = {1'b0, byte_index} + 17'd1;
        if (len17 > {1'b0, payload_size})
        begin
            len17 = {1'b0, payload_size};
        end
        if (len17 > 17'(MAX_PAYLOAD))
        begin
            len17 = 17'(MAX_PAYLOAD);
        end
        commit_len = len17[LEN_W-1:0];

        cur_len  = slot_len[drain_slot_reg];
        off_inc  = {1'b0, drain_off_reg} + (LEN_W+1)'(1);
        slot_inc = {1'b0, drain_slot_reg} + (SLOT_W+1)'(1);
        recv_inc = '0;
        tot_inc  = '0;

        if (cmd.accept)
        begin
            if (action == ACT_DRAIN)
            begin
                if (!draining_reg)
                begin
                    status_next = STS_NO_DRAIN;
                end
                else
                begin
                    // step the drain pointer; final byte closes the frame
                    drain_last_next = 1'b0;
                    drain_off_next  = off_inc[LEN_W-1:0];
                    if (off_inc >= {1'b0, cur_len})
                    begin
                        drain_off_next  = '0;
                        drain_slot_next = slot_inc[SLOT_W-1:0];
                        if (slot_inc >= (SLOT_W+1)'(expected_reg))
                        begin
                            drain_last_next   = 1'b1;
                            filled_next       = '0;
                            frame_active_next = 1'b0;
                            expected_next     = '0;
                            received_next     = '0;
                            total_next        = '0;
                            draining_next     = 1'b0;
                            drain_slot_next   = '0;
                        end
                    end
                end
            end
            else if (draining_reg)
            begin
                status_next = STS_BUSY;
            end
            else if (byte_index == 16'd0)
            begin
                // header check on the first byte
                if (!hdr_ok)
                begin
                    ignoring_next   = 1'b1;
                    ignore_dup_next = 1'b0;
                    status_next     = STS_BAD_HEADER;
                end
                else
                begin
                    restart_f = frame_active_reg
                             && ((pending_id_reg != frame_id)
                             || (16'(expected_reg) != chunk_count));
                    open_f    = !frame_active_reg || restart_f;
                    restarted_next = restart_f;
                    if (open_f)
                    begin
                        filled_next       = '0;
                        frame_active_next = 1'b1;
                        pending_id_next   = frame_id;
                        expected_next     = CNT_W'(chunk_count);
                        received_next     = '0;
                        total_next        = '0;
                    end
                    if (!open_f && filled_reg[chunk_number[SLOT_W-1:0]])
                    begin
                        ignoring_next   = 1'b1;
                        ignore_dup_next = 1'b1;
                        status_next     = STS_DUPLICATE;
                    end
                    else
                    begin
                        cur_slot_next   = chunk_number[SLOT_W-1:0];
                        wr_slot         = chunk_number[SLOT_W-1:0];
                        ignoring_next   = 1'b0;
                        ignore_dup_next = 1'b0;
                        proceed         = 1'b1;
                    end
                end
            end
            else if (ignoring_reg || !frame_active_reg)
            begin
                status_next = ignore_dup_reg ? STS_DUPLICATE : STS_BAD_HEADER;
            end
            else
            begin
                proceed = 1'b1;
            end

            // store the byte and commit the chunk on its last byte
            if (proceed)
            begin
                mem_we = (byte_index < payload_size)
                      && ({1'b0, byte_index} < 17'(MAX_PAYLOAD));
                if (byte_last)
                begin
                    len_we = 1'b1;
                    recv_inc = received_next + CNT_W'(1);
                    tot_inc  = total_next + 15'(commit_len);
                    filled_next[wr_slot] = 1'b1;
                    received_next   = recv_inc;
                    total_next      = tot_inc;
                    ignoring_next   = 1'b1;
                    ignore_dup_next = 1'b0;
                    if (recv_inc >= expected_next)
                    begin
                        status_next       = STS_COMPLETE;
                        frame_size_next   = tot_inc;
                        frame_type_next   = packet_type;
                        done_id_next      = pending_id_next;
                        draining_next     = 1'b1;
                        drain_slot_next   = '0;
                        drain_off_next    = '0;
                        frame_active_next = 1'b0;
                    end
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg <= 1'b0;
            pending_id_reg   <= '0;
            expected_reg     <= '0;
            received_reg     <= '0;
            total_reg        <= '0;
            filled_reg       <= '0;
            ignoring_reg     <= 1'b0;
            ignore_dup_reg   <= 1'b0;
            cur_slot_reg     <= '0;
            draining_reg     <= 1'b0;
            drain_slot_reg   <= '0;
            drain_off_reg    <= '0;
            drain_last_reg   <= 1'b0;
        end
        else
        begin
            frame_active_reg <= frame_active_next;
            pending_id_reg   <= pending_id_next;
            expected_reg     <= expected_next;
            received_reg     <= received_next;
            total_reg        <= total_next;
            filled_reg       <= filled_next;
            ignoring_reg     <= ignoring_next;
            ignore_dup_reg   <= ignore_dup_next;
            cur_slot_reg     <= cur_slot_next;
            draining_reg     <= draining_next;
            drain_slot_reg   <= drain_slot_next;
            drain_off_reg    <= drain_off_next;
            drain_last_reg   <= drain_last_next;
        end
    end

    // slot length table
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            slot_len[wr_slot] <= commit_len;
        end
    end

    // payload memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= data_byte;
        end
        if (cmd.accept && sts.drain_read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_drain)
        begin
            status_reg     <= STS_DRAIN_BYTE;
            restarted_reg  <= 1'b0;
            out_byte_reg   <= rd_data_reg;
            out_last_reg   <= drain_last_reg;
            frame_size_reg <= '0;
            frame_type_reg <= '0;
            done_id_reg    <= '0;
        end
        else if (cmd.accept && !sts.drain_read)
        begin
            status_reg     <= status_next;
            restarted_reg  <= restarted_next;
            out_byte_reg   <= '0;
            out_last_reg   <= out_last_next;
            frame_size_reg <= frame_size_next;
            frame_type_reg <= frame_type_next;
            done_id_reg    <= done_id_next;
        end
    end

    assign status        = status_reg;
    assign restarted     = restarted_reg;
    assign out_byte      = out_byte_reg;
    assign out_last      = out_last_reg;
    assign frame_size    = frame_size_reg;
    assign frame_type    = frame_type_reg;
    assign done_frame_id = done_id_reg;

endmodule

FILE: hw/rtl/chunk_reassembly_buffer_top.sv
// ----------------------------------------------------------------------------
// chunk_reassembly_buffer_top
// Rebuilds one frame from out-of-order chunks and drains it in slot order.
// ----------------------------------------------------------------------------
// For a chunk byte, the header check, slot bookkeeping and payload memory
// write all happen at the accepting edge, and the next item is taken in the
// following cycle. A drain item with a frame to read passes the registered
// read port of the payload memory and then the result register; input
// stalls while that read is outstanding. One result per item, held in an
// output register; input stalls while a result waits there under stall,
// and a new item is taken at the same edge that the waiting result leaves.
module chunk_reassembly_buffer_top
    import crb_pkg::*;
#(
    parameter int MAX_CHUNKS  = 16,
    parameter int MAX_PAYLOAD = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] frame_id,
    input  logic [15:0] chunk_count,
    input  logic [15:0] chunk_number,
    input  logic [15:0] payload_size,
    input  logic [15:0] byte_index,
    input  logic [7:0]  data_byte,
    input  logic        byte_last,
    input  logic [7:0]  packet_type,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        restarted,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic [14:0] frame_size,
    output logic [7:0]  frame_type,
    output logic [31:0] done_frame_id
);

    crb_cmd_t cmd;
    crb_sts_t sts;

    crb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    crb_datapath #(
        .MAX_CHUNKS  (MAX_CHUNKS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .frame_id      (frame_id),
        .chunk_count   (chunk_count),
        .chunk_number  (chunk_number),
        .payload_size  (payload_size),
        .byte_index    (byte_index),
        .data_byte     (data_byte),
        .byte_last     (byte_last),
        .packet_type   (packet_type),
        .status        (status),
        .restarted     (restarted),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .frame_size    (frame_size),
        .frame_type    (frame_type),
        .done_frame_id (done_frame_id)
    );

`ifndef NO_ASSERTIONS
    // a pending drain read blocks new items
    a_no_accept_on_drain_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_drain |-> !cmd.accept
    ) else $error("item accepted while drain byte is loading");

    // a direct item shows its result in the next cycle
    a_direct_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.accept && !sts.drain_read) |=> out_valid
    ) else $error("result missing after direct item");

    // a drain read leaves the output empty until the byte arrives
    a_drain_gap: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.accept && sts.drain_read) |=> !out_valid
    ) else $error("stale result during drain read");
`endif

endmodule

FILE: tb/sv/tb_chunk_reassembly_buffer_top.sv
// ----------------------------------------------------------------------------
// tb_chunk_reassembly_buffer_top
// Self-checking bench for the chunk reassembly buffer: directed header and
// drain cases, then randomized frames with out-of-order, short, long,
// abandoned and duplicate chunks and interleaved noise. Every accepted item
// is predicted in the bench, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_chunk_reassembly_buffer_top;
    import crb_pkg::*;

    localparam int NSLOTS     = 16;
    localparam int SLOT_BYTES = 1024;
    localparam int CYCLE_CAP  = 600000;

    typedef struct {
        logic        action;
        logic [31:0] frame_id;
        logic [15:0] chunk_count;
        logic [15:0] chunk_number;
        logic [15:0] payload_size;
        logic [15:0] byte_index;
        logic [7:0]  data_byte;
        logic        byte_last;
        logic [7:0]  packet_type;
    } chunk_item_t;

    typedef struct {
        logic [2:0]  status;
        logic        restarted;
        logic [7:0]  out_byte;
        logic        out_last;
        logic [14:0] frame_size;
        logic [7:0]  frame_type;
        logic [31:0] done_frame_id;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = ACT_CHUNK;
    logic [31:0] frame_id = '0;
    logic [15:0] chunk_count = '0;
    logic [15:0] chunk_number = '0;
    logic [15:0] payload_size = '0;
    logic [15:0] byte_index = '0;
    logic [7:0]  data_byte = '0;
    logic        byte_last = 1'b0;
    logic [7:0]  packet_type = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        restarted;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [14:0] frame_size;
    logic [7:0]  frame_type;
    logic [31:0] done_frame_id;

    chunk_reassembly_buffer_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .frame_id(frame_id), .chunk_count(chunk_count),
        .chunk_number(chunk_number), .payload_size(payload_size),
        .byte_index(byte_index), .data_byte(data_byte), .byte_last(byte_last),
        .packet_type(packet_type),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .restarted(restarted), .out_byte(out_byte),
        .out_last(out_last), .frame_size(frame_size), .frame_type(frame_type),
        .done_frame_id(done_frame_id)
    );

    always #1 clk = ~clk;

    // mirror of the block state
    bit          m_active;
    bit [31:0]   m_pending_id;
    int          m_expected;
    int          m_received;
    int          m_total;
    bit          m_filled [NSLOTS];
    int          m_slot_len [NSLOTS];
    bit [7:0]    m_store [NSLOTS*SLOT_BYTES];
    bit          m_written [NSLOTS*SLOT_BYTES];
    bit          m_ignoring;
    bit          m_ignore_dup;
    int          m_cur_slot;
    bit          m_draining;
    int          m_drain_slot;
    int          m_drain_off;
    bit [7:0]    m_last_type;

    frame_result_t expected_q[$];
    int  errors;
    int  items_sent;
    int  results_seen;
    int  frames_done;
    int  cycles;
    int  send_idle_pct;
    int  recv_stall_pct;

    function automatic void clear_frame();
        foreach (m_filled[i]) m_filled[i] = 0;
        m_active = 0;
        m_expected = 0;
        m_received = 0;
        m_total = 0;
        m_draining = 0;
        m_drain_slot = 0;
        m_drain_off = 0;
    endfunction

    function automatic void start_frame(bit [31:0] id, int count);
        foreach (m_filled[i]) m_filled[i] = 0;
        m_active = 1;
        m_pending_id = id;
        m_expected = count;
        m_received = 0;
        m_total = 0;
    endfunction

    // predicted result of one accepted item
    function automatic frame_result_t reassemble(chunk_item_t it);
        frame_result_t r;
        int len;
        bit ok;
        r = '{default: '0};
        if (it.action == ACT_DRAIN) begin
            if (!m_draining) begin
                r.status = STS_NO_DRAIN;
                return r;
            end
            len = m_slot_len[m_drain_slot];
            r.status = STS_DRAIN_BYTE;
            if (m_drain_off < len)
                r.out_byte = m_store[m_drain_slot*SLOT_BYTES + m_drain_off];
            m_drain_off++;
            if (m_drain_off >= len) begin
                m_drain_off = 0;
                m_drain_slot++;
                if (m_drain_slot >= m_expected) begin
                    r.out_last = 1;
                    clear_frame();
                end
            end
            return r;
        end
        if (m_draining) begin
            r.status = STS_BUSY;
            return r;
        end
        if (it.byte_index == 0) begin
            ok = it.chunk_count > 0 && it.chunk_count <= NSLOTS &&
                 it.chunk_number < it.chunk_count &&
                 it.payload_size > 0 && it.payload_size <= SLOT_BYTES;
            if (!ok) begin
                m_ignoring = 1;
                m_ignore_dup = 0;
                r.status = STS_BAD_HEADER;
                return r;
            end
            if (!m_active) begin
                start_frame(it.frame_id, it.chunk_count);
            end
            else if (m_pending_id != it.frame_id || m_expected != it.chunk_count) begin
                start_frame(it.frame_id, it.chunk_count);
                r.restarted = 1;
            end
            if (m_filled[it.chunk_number]) begin
                m_ignoring = 1;
                m_ignore_dup = 1;
                r.status = STS_DUPLICATE;
                return r;
            end
            m_cur_slot = it.chunk_number;
            m_ignoring = 0;
            m_ignore_dup = 0;
        end
        else if (m_ignoring || !m_active) begin
            r.status = m_ignore_dup ? STS_DUPLICATE : STS_BAD_HEADER;
            return r;
        end
        if (it.byte_index < it.payload_size && it.byte_index < SLOT_BYTES) begin
            m_store[m_cur_slot*SLOT_BYTES + it.byte_index] = it.data_byte;
            m_written[m_cur_slot*SLOT_BYTES + it.byte_index] = 1;
        end
        r.status = STS_ACCEPTED;
        if (it.byte_last) begin
            len = int'(it.byte_index) + 1;
            if (len > it.payload_size) len = it.payload_size;
            m_slot_len[m_cur_slot] = len;
            m_filled[m_cur_slot] = 1;
            m_total += len;
            m_received++;
            m_ignoring = 1;
            m_ignore_dup = 0;
            if (m_received >= m_expected) begin
                m_last_type = it.packet_type;
                r.status = STS_COMPLETE;
                r.frame_size = m_total[14:0];
                r.frame_type = m_last_type;
                r.done_frame_id = m_pending_id;
                m_draining = 1;
                m_drain_slot = 0;
                m_drain_off = 0;
                m_active = 0;
                frames_done++;
            end
        end
        return r;
    endfunction

    // drive one item and wait for it to be taken
    task automatic send_item(input chunk_item_t it);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action       <= it.action;
        frame_id     <= it.frame_id;
        chunk_count  <= it.chunk_count;
        chunk_number <= it.chunk_number;
        payload_size <= it.payload_size;
        byte_index   <= it.byte_index;
        data_byte    <= it.data_byte;
        byte_last    <= it.byte_last;
        packet_type  <= it.packet_type;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall);
        expected_q.push_back(reassemble(it));
        items_sent++;
    endtask

    task automatic send_byte(bit [31:0] id, int count, int num, int psize, int bidx,
                             bit last, bit [7:0] ptype);
        chunk_item_t it;
        it = '{ACT_CHUNK, id, count[15:0], num[15:0], psize[15:0], bidx[15:0],
               8'($urandom), last, ptype};
        send_item(it);
    endtask

    task automatic send_drain();
        chunk_item_t it;
        it = '{ACT_DRAIN, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 8'($urandom), 1'($urandom), 8'($urandom)};
        send_item(it);
    endtask

    // random item with a nonzero byte index; only sent between chunks
    task automatic send_stray();
        chunk_item_t it;
        it = '{ACT_CHUNK, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom_range(65535, 1)), 8'($urandom), 1'($urandom),
               8'($urandom)};
        send_item(it);
    endtask

    // header that breaks at least one rule, plus a follower byte
    task automatic send_bad_header();
        int kind;
        int cnt;
        int num;
        int ps;
        kind = $urandom_range(4);
        cnt = $urandom_range(NSLOTS, 1);
        num = $urandom_range(cnt - 1);
        ps = $urandom_range(SLOT_BYTES, 1);
        case (kind)
            0: cnt = 0;
            1: cnt = $urandom_range(65535, NSLOTS + 1);
            2: num = $urandom_range(65535, cnt);
            3: ps = 0;
            default: ps = $urandom_range(65535, SLOT_BYTES + 1);
        endcase
        send_byte($urandom, cnt, num, ps, 0, 1'($urandom_range(1)), 8'($urandom));
        send_byte($urandom, cnt, num, ps, 1, 1'($urandom_range(1)), 8'($urandom));
    endtask

    // one chunk of n bytes; skips only positions already holding data
    task automatic send_chunk(bit [31:0] id, int count, int num, int psize, int n);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && i < n - 1 && i < psize &&
                m_written[num*SLOT_BYTES + i] && $urandom_range(7) == 0)
                continue;
            send_byte(id, count, num, psize, i, i == n - 1, 8'($urandom));
        end
    endtask

    task automatic drain_frame();
        while (m_draining)
        begin
            if ($urandom_range(19) == 0)
                send_byte($urandom, 1, 0, 1, 0, 1, 8'($urandom));
            send_drain();
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_q.size() > 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // one frame in random slot order; may be cut short to force a restart
    task automatic send_frame(int count, int pmax, bit noisy);
        bit [31:0] id;
        int order[$];
        int ps;
        int n;
        int cut;
        id = $urandom;
        for (int i = 0; i < count; i++) order.push_back(i);
        order.shuffle();
        cut = (noisy && $urandom_range(14) == 0) ? $urandom_range(count - 1) : count;
        for (int k = 0; k < cut; k++)
        begin
            ps = $urandom_range(pmax, 1);
            case ($urandom_range(5))
                0: n = $urandom_range(ps, 1);
                1: n = ps + $urandom_range(3, 1);
                default: n = ps;
            endcase
            if (noisy && $urandom_range(9) == 0)
                send_byte(id, count, order[k], ps, 0, 0, 8'($urandom));
            send_chunk(id, count, order[k], ps, n);
            if (noisy && k < cut - 1)
            begin
                case ($urandom_range(11))
                    0: send_stray();
                    1: send_bad_header();
                    2: send_drain();
                    3: send_chunk(id, count, order[0], 4, 2);
                    default: ;
                endcase
            end
        end
        drain_frame();
        if (noisy && $urandom_range(3) == 0) send_drain();
    endtask

    // header extremes, idle drain, busy, single-chunk frames
    task automatic test_directed();
        send_drain();
        send_byte(32'h0, 0, 0, 8, 0, 0, 8'h00);
        send_byte(32'h0, 17, 0, 8, 0, 0, 8'hff);
        send_byte(32'hffffffff, 65535, 0, 8, 0, 1, 8'h55);
        send_byte(32'h1, 4, 4, 8, 0, 0, 8'h0);
        send_byte(32'h1, 4, 65535, 8, 0, 0, 8'h0);
        send_byte(32'h1, 4, 0, 0, 0, 0, 8'h0);
        send_byte(32'h1, 4, 0, 1025, 0, 0, 8'h0);
        send_byte(32'h1, 4, 0, 65535, 0, 1, 8'h0);
        send_byte(32'h1, 4, 0, 8, 65535, 1, 8'haa);
        send_stray();
        send_byte(32'hffffffff, 1, 0, 1, 0, 1, 8'hff);
        send_byte(32'h2, 1, 0, 2, 0, 1, 8'h00);
        send_drain();
        send_drain();
        send_byte(32'h0, 1, 0, 2, 0, 0, 8'h7e);
        send_byte(32'h0, 1, 0, 2, 1, 1, 8'h81);
        send_byte(32'h0, 1, 0, 2, 0, 1, 8'h00);
        send_drain();
        send_drain();
        send_drain();
        wait_for_results();
    endtask

    // largest declared size as a short chunk, and all sixteen slots
    task automatic test_extremes();
        bit [31:0] id;
        id = $urandom;
        send_chunk(id, 1, 0, SLOT_BYTES, 3);
        drain_frame();
        send_frame(NSLOTS, 4, 1'b0);
        send_frame(NSLOTS, 1, 1'b0);
    endtask

    task automatic test_random_frames(int idle_pct, int stall_pct, int n_items);
        int stop_at;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(7) == 0)
                send_frame($urandom_range(NSLOTS, 1), 8, 1'b1);
            else
                send_frame($urandom_range(4, 1), 6, 1'b1);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        frame_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: status %0d", status);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, status);
                    errors++;
                end
                if (restarted !== e.restarted)
                begin
                    $error("restarted exp %0d got %0d", e.restarted, restarted);
                    errors++;
                end
                if (out_byte !== e.out_byte)
                begin
                    $error("out_byte exp %0h got %0h", e.out_byte, out_byte);
                    errors++;
                end
                if (out_last !== e.out_last)
                begin
                    $error("out_last exp %0d got %0d", e.out_last, out_last);
                    errors++;
                end
                if (frame_size !== e.frame_size)
                begin
                    $error("frame_size exp %0d got %0d", e.frame_size, frame_size);
                    errors++;
                end
                if (frame_type !== e.frame_type)
                begin
                    $error("frame_type exp %0h got %0h", e.frame_type, frame_type);
                    errors++;
                end
                if (done_frame_id !== e.done_frame_id)
                begin
                    $error("done_frame_id exp %0h got %0h", e.done_frame_id,
                           done_frame_id);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        frames_done = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        m_pending_id = 0;
        m_ignoring = 0;
        m_ignore_dup = 0;
        m_cur_slot = 0;
        m_last_type = 0;
        clear_frame();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_extremes();
        test_random_frames(0, 0, 340);
        test_random_frames(60, 0, 340);
        test_random_frames(0, 60, 340);
        test_random_frames(20, 20, 340);

        in_valid <= 1'b0;
        while (expected_q.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("sent %0d items, checked %0d results, %0d frames completed",
                 items_sent, results_seen, frames_done);
        $display("covered header errors, duplicates, restarts, short and long chunks");
        if (errors == 0 && expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/crb_pkg.sv
hw/rtl/crb_ctrl.sv
hw/rtl/crb_datapath.sv
hw/rtl/chunk_reassembly_buffer_top.sv
tb/sv/tb_chunk_reassembly_buffer_top.sv
